// File: src/cms_pkg.sv
// cms_pkg: shared constants, command and status types for the count-min sketch
// used by the controller, the datapath and the top level
// depends on nothing
`timescale 1ns / 1ps

package cms_pkg;

    // default sizes handed to the top-level parameters
    localparam int TABLE_SIZE_DEF  = 503;
    localparam int COUNT_WIDTH_DEF = 32;

    // hash widths and start values
    localparam int          HASH_W     = 64;
    localparam int          DJB1_W     = 32;
    localparam int          BYTE_W     = 8;
    localparam logic [63:0] DJB2_START = 64'd5381;

    // remainder unit: fold 16-bit digits into a 30-bit sum, estimate the
    // quotient by a reciprocal, subtract it back out, then one correction
    localparam int FOLD_W    = 16;
    localparam int SUM_W     = 30;
    localparam int RECIP_SH  = SUM_W;
    localparam int RED_STEPS = 4;
    localparam int RED_CNT_W = $clog2(RED_STEPS);

    // estimate width on the result port
    localparam int EST_W = 32;

    // request opcodes
    localparam logic OP_INC   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic clear;   // write zero at the clear address, advance it
        logic hash_en; // a byte is taken: update the running hashes
        logic load;    // last byte: hand finished hashes to the remainder units
        logic reduce;  // one remainder step
        logic read;    // read the three selected counters
        logic finish;  // write back the increment or emit the estimate
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clear_last;  // clear address at the final entry
        logic reduce_last; // final remainder step in progress
    } t_stat;

endpackage

// File: src/cms_mod.sv
// cms_mod: remainder of a 64-bit hash by the table size over four steps
// depends on cms_pkg
`timescale 1ns / 1ps

module cms_mod
    import cms_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  logic                          i_step,
    input  logic [HASH_W-1:0]             i_value,
    output logic [$clog2(TABLE_SIZE)-1:0] o_rem
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int REM_W = IDX_W + 1;
    localparam int PROD_W = 2 * SUM_W;

    // 2^bits mod TABLE_SIZE, worked out at elaboration
    function automatic int fold_weight(input int bits);
        int w;
        w = 1 % TABLE_SIZE;
        for (int b = 0; b < bits; b++) begin
            w = (w * 2) % TABLE_SIZE;
        end
        return w;
    endfunction

    localparam logic [SUM_W-1:0] W1    = SUM_W'(fold_weight(FOLD_W));
    localparam logic [SUM_W-1:0] W2    = SUM_W'(fold_weight(2 * FOLD_W));
    localparam logic [SUM_W-1:0] W3    = SUM_W'(fold_weight(3 * FOLD_W));
    localparam logic [SUM_W-1:0] MOD_S = SUM_W'(TABLE_SIZE);
    localparam logic [SUM_W-1:0] RECIP = SUM_W'((1 << RECIP_SH) / TABLE_SIZE);

    logic [HASH_W-1:0] r_value;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [SUM_W-1:0]  r_quot, n_quot;
    logic [REM_W-1:0]  r_part, n_part;
    logic [IDX_W-1:0]  r_rem, n_rem;
    logic [PROD_W-1:0] w_prod;
    logic [SUM_W-1:0]  w_back;
    logic [SUM_W-1:0]  w_diff;

    // fold the four 16-bit digits by their weights, sum stays below 2^30
    always_comb begin
        n_sum = SUM_W'(r_value[FOLD_W-1:0])
              + SUM_W'(r_value[FOLD_W   +: FOLD_W]) * W1
              + SUM_W'(r_value[2*FOLD_W +: FOLD_W]) * W2
              + SUM_W'(r_value[3*FOLD_W +: FOLD_W]) * W3;
    end

    // quotient estimate, at most one short of the true quotient
    always_comb begin
        w_prod = PROD_W'(r_sum) * PROD_W'(RECIP);
        n_quot = w_prod[RECIP_SH +: SUM_W];
    end

    // partial remainder, below twice the table size
    always_comb begin
        w_back = r_quot * MOD_S;
        w_diff = r_sum - w_back;
        n_part = w_diff[REM_W-1:0];
    end

    // final correction
    always_comb begin
        if (r_part >= REM_W'(TABLE_SIZE)) begin
            n_rem = IDX_W'(r_part - REM_W'(TABLE_SIZE));
        end else begin
            n_rem = r_part[IDX_W-1:0];
        end
    end

    // hash capture on load; pipeline stages, all advanced on each step
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_value <= i_value;
        end
        if (i_step) begin
            r_sum  <= n_sum;
            r_quot <= n_quot;
            r_part <= n_part;
            r_rem  <= n_rem;
        end
    end

    assign o_rem = r_rem;

endmodule

// File: src/cms_ctrl.sv
// cms_ctrl: controller state machine for the count-min sketch
// depends on cms_pkg
`timescale 1ns / 1ps

module cms_ctrl
    import cms_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    input  logic  i_last,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  busy
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_REDUCE = 3'd2;
    localparam logic [2:0] S_READ   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       w_take;

    assign w_take = start && (r_state == S_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (i_stat.clear_last) n_state = S_IDLE;
            S_IDLE:   if (w_take && i_last) n_state = S_REDUCE;
            S_REDUCE: if (i_stat.reduce_last) n_state = S_READ;
            S_READ:   n_state = S_FINISH;
            S_FINISH: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // commands to the datapath
    always_comb begin
        o_cmd         = '0;
        o_cmd.clear   = (r_state == S_CLEAR);
        o_cmd.hash_en = w_take;
        o_cmd.load    = w_take && i_last;
        o_cmd.reduce  = (r_state == S_REDUCE);
        o_cmd.read    = (r_state == S_READ);
        o_cmd.finish  = (r_state == S_FINISH);
    end

    assign busy = (r_state != S_IDLE);

endmodule

// File: src/cms_dp.sv
// cms_dp: datapath of the count-min sketch: hashes, remainder units,
// the three counter rows and the estimate register; depends on cms_pkg, cms_mod
`timescale 1ns / 1ps

module cms_dp
    import cms_pkg::*;
#(
    parameter int TABLE_SIZE  = TABLE_SIZE_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic              i_op,
    input  logic [BYTE_W-1:0] i_key_byte,
    input  logic              i_last,
    output logic [EST_W-1:0]  o_estimate,
    output logic              o_valid
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int EXT_W = (COUNT_WIDTH > EST_W) ? COUNT_WIDTH : EST_W;

    logic [HASH_W-1:0] r_sdbm, r_djb2, n_sdbm, n_djb2;
    logic [DJB1_W-1:0] r_djb1, n_djb1;
    logic [HASH_W-1:0] w_byte64;
    logic [HASH_W-1:0] w_fin [3];

    logic [IDX_W-1:0]     r_clr_addr;
    logic [RED_CNT_W-1:0] r_step_cnt;
    logic                 r_op;

    logic [IDX_W-1:0]       w_idx [3];
    logic [COUNT_WIDTH-1:0] r_rd  [3];

    logic [COUNT_WIDTH-1:0] w_min01, w_min;
    logic [EXT_W-1:0]       w_min_ext;
    logic [EST_W-1:0]       w_est;
    logic [EST_W-1:0]       r_est;
    logic                   r_valid;

    // next hash values for the byte on the request
    always_comb begin
        w_byte64 = HASH_W'(i_key_byte);
        n_sdbm   = w_byte64 + (r_sdbm << 6) + (r_sdbm << 16) - r_sdbm;
        n_djb2   = (r_djb2 << 5) + r_djb2 + w_byte64;
        n_djb1   = (r_djb1 << 5) + r_djb1 + DJB1_W'(i_key_byte);
    end

    assign w_fin[0] = n_sdbm;
    assign w_fin[1] = n_djb2;
    assign w_fin[2] = HASH_W'(n_djb1);

    // running hashes, restarted after the last byte of a key
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sdbm <= '0;
            r_djb2 <= DJB2_START;
            r_djb1 <= '0;
        end else if (i_cmd.hash_en) begin
            if (i_last) begin
                r_sdbm <= '0;
                r_djb2 <= DJB2_START;
                r_djb1 <= '0;
            end else begin
                r_sdbm <= n_sdbm;
                r_djb2 <= n_djb2;
                r_djb1 <= n_djb1;
            end
        end
    end

    // clear address and remainder step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_step_cnt <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.load) begin
                r_step_cnt <= '0;
            end else if (i_cmd.reduce) begin
                r_step_cnt <= r_step_cnt + 1'b1;
            end
        end
    end

    assign o_stat.clear_last  = (r_clr_addr == IDX_W'(TABLE_SIZE - 1));
    assign o_stat.reduce_last = i_cmd.reduce && (r_step_cnt == RED_CNT_W'(RED_STEPS - 1));

    // opcode of the key being finished
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_op;
        end
    end

    // one remainder unit and one counter row per hash
    for (genvar g = 0; g < 3; g++) begin : g_row
        logic [COUNT_WIDTH-1:0] r_mem [TABLE_SIZE];
        logic [COUNT_WIDTH-1:0] w_bump;

        cms_mod #(
            .TABLE_SIZE(TABLE_SIZE)
        ) u_mod (
            .i_clk   (i_clk),
            .i_load  (i_cmd.load),
            .i_step  (i_cmd.reduce),
            .i_value (w_fin[g]),
            .o_rem   (w_idx[g])
        );

        // saturating increment
        assign w_bump = (r_rd[g] == {COUNT_WIDTH{1'b1}}) ? r_rd[g] : r_rd[g] + 1'b1;

        // counter memory: one write port, registered read
        always_ff @(posedge i_clk) begin
            if (i_cmd.clear) begin
                r_mem[r_clr_addr] <= '0;
            end else if (i_cmd.finish && (r_op == OP_INC)) begin
                r_mem[w_idx[g]] <= w_bump;
            end
            if (i_cmd.read) begin
                r_rd[g] <= r_mem[w_idx[g]];
            end
        end
    end

    // minimum of the three counters, clipped to the port width
    always_comb begin
        w_min01   = (r_rd[0] < r_rd[1]) ? r_rd[0] : r_rd[1];
        w_min     = (w_min01 < r_rd[2]) ? w_min01 : r_rd[2];
        w_min_ext = EXT_W'(w_min);
        if (w_min_ext > EXT_W'({EST_W{1'b1}})) begin
            w_est = {EST_W{1'b1}};
        end else begin
            w_est = w_min_ext[EST_W-1:0];
        end
    end

    // result register and strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish && (r_op == OP_QUERY);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_est <= w_est;
        end
    end

    assign o_estimate = r_est;
    assign o_valid    = r_valid;

endmodule

// File: src/count_min_sketch_three_hash.sv
// count_min_sketch_three_hash: top level of the three-row count-min sketch
// depends on cms_pkg, cms_ctrl, cms_dp
`timescale 1ns / 1ps
//
// Usage:
// - A key is sent one byte per request: i_key_byte with i_last high on the
//   final byte; i_op (increment or query) is only looked at on that byte.
// - A request is taken at a rising edge where start is high and busy is low.
// - An inner byte keeps busy low, so the next byte may follow.
// - A last byte runs the three remainders in four steps (digit fold,
//   reciprocal quotient, subtract, correction), then a counter read and a
//   write-back or compare; busy stays high until the write-back or compare
//   is done, and the next request is taken after that.
// - A query puts its estimate on o_estimate with o_valid high for one cycle,
//   both registered after the compare; an increment gives no result.
// - The receiver cannot stall: o_valid is a strobe and must be captured.
// - Reset (i_rst_n low, synchronous) restarts the hashes and then clears the
//   counter rows one entry per cycle; busy stays high while all TABLE_SIZE
//   entries (503 by default) are cleared, before the first request is taken.
//
module count_min_sketch_three_hash
    import cms_pkg::*;
#(
    parameter int TABLE_SIZE  = TABLE_SIZE_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_op,
    input  logic [BYTE_W-1:0] i_key_byte,
    input  logic              i_last,
    output logic [EST_W-1:0]  o_estimate,
    output logic              o_valid
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencing
    cms_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_last  (i_last),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .busy    (busy)
    );

    // hashes, counters and result
    cms_dp #(
        .TABLE_SIZE  (TABLE_SIZE),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_op       (i_op),
        .i_key_byte (i_key_byte),
        .i_last     (i_last),
        .o_estimate (o_estimate),
        .o_valid    (o_valid)
    );

endmodule

// File: src/cms_check.sv
// cms_check: port-level checks on the count-min sketch top level
// depends on cms_pkg; bound to count_min_sketch_three_hash below
`timescale 1ns / 1ps

module cms_check
    import cms_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              i_last,
    input logic [EST_W-1:0]  o_estimate,
    input logic              o_valid
);

    // reset always starts a clearing pass
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("no clearing pass after reset");

    // a last byte keeps the block busy for the reduction
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_last) |=> busy)
        else $error("busy low after a last byte");

    // an inner byte gives no result
    a_inner_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_last) |=> !o_valid)
        else $error("result after an inner byte");

    // results come one at a time, with the block ready again
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!busy && !$past(o_valid)))
        else $error("result strobe repeated or while busy");

    // a reported estimate is always a known value
    a_known_estimate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !$isunknown(o_estimate))
        else $error("unknown estimate on the result strobe");

endmodule

bind count_min_sketch_three_hash cms_check u_cms_check (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .i_last     (i_last),
    .o_estimate (o_estimate),
    .o_valid    (o_valid)
);
